@@ hw/rtl/mbps_pkg.sv @@
// shared types and constants for the masked byte pattern scanner
package mbps_pkg;

	// largest pattern the window can hold by default
	localparam int PATTERN_MAX_DEF = 16;

	// field widths fixed by the interface
	localparam int ADDR_W = 64;
	localparam int LEN_W  = 5;
	localparam int CARE_W = 16;
	localparam int IDX_W  = 3;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_BASE_ADDRESS   = 3'd0,
		REG_PATTERN_LOW    = 3'd1,
		REG_PATTERN_HIGH   = 3'd2,
		REG_CARE_MASK      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_idx_t;

	// one input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       readable;
		logic       new_region;
		logic       last_byte;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	// current register contents handed to the datapath
	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [63:0]       pattern_low;
		logic [63:0]       pattern_high;
		logic [CARE_W-1:0] care_mask;
		logic [LEN_W-1:0]  pattern_length;
	} cfg_t;

endpackage

@@ hw/rtl/mbps_cfg.sv @@
// configuration register file of the pattern scanner
module mbps_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [mbps_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0]               cfg_data,
	output mbps_pkg::cfg_t            cfg
);

	mbps_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (mbps_pkg::cfg_idx_t'(cfg_index))
				mbps_pkg::REG_BASE_ADDRESS: begin
					cfg_q.base_address <= cfg_data;
				end
				mbps_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				mbps_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				mbps_pkg::REG_CARE_MASK: begin
					cfg_q.care_mask <= cfg_data[mbps_pkg::CARE_W-1:0];
				end
				mbps_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[mbps_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/mbps_match.sv @@
// masked compare of the byte window against the pattern
module mbps_match #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  logic [PATTERN_MAX-1:0][7:0]         win,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]     fill,
	input  mbps_pkg::cfg_t                       cfg,
	output logic                                 hit
);

	localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [127:0] pattern;
	logic         len_ok;
	logic         mismatch;

	assign pattern = {cfg.pattern_high, cfg.pattern_low};

	// length must be nonzero, fit the window, and the window must be full enough
	assign len_ok = (cfg.pattern_length != '0) &&
	                (cfg.pattern_length <= mbps_pkg::LEN_W'(PATTERN_MAX)) &&
	                (mbps_pkg::LEN_W'(fill) >= cfg.pattern_length);

	// pattern byte i lines up with the i-th of the newest len window bytes
	always_comb begin
		logic [WIN_IDX_W-1:0] idx;
		logic                 cares;
		mismatch = 1'b0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			idx   = WIN_IDX_W'(PATTERN_MAX + i - int'(cfg.pattern_length));
			cares = cfg.care_mask[i] && (mbps_pkg::LEN_W'(i) < cfg.pattern_length);
			if (cares && (win[idx] != pattern[8*i +: 8])) begin
				mismatch = 1'b1;
			end
		end
	end

	assign hit = len_ok && !mismatch;

endmodule

@@ hw/rtl/mbps_scan.sv @@
// input stage, scan state and result register of the pattern scanner
module mbps_scan #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbps_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  mbps_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mbps_pkg::out_item_t out_data
);

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	mbps_pkg::in_item_t          item_s1;
	logic                        valid_s1;
	logic                        go_s1;
	logic                        fire_s1;

	logic [PATTERN_MAX-1:0][7:0] window_q;
	logic [PATTERN_MAX-1:0][7:0] win_nxt;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           fill_base;
	logic [FILL_W-1:0]           fill_nxt;
	logic [mbps_pkg::ADDR_W-1:0] pos_q;
	logic                        seen_q;
	logic [mbps_pkg::ADDR_W-1:0] first_q;
	logic                        hit;
	logic                        take;
	logic                        seen_nxt;
	logic [mbps_pkg::ADDR_W-1:0] first_nxt;
	logic [mbps_pkg::ADDR_W-1:0] cand_addr;

	logic                        out_valid_q;
	mbps_pkg::out_item_t         out_q;

	// stage 1 moves on unless it carries a result and the result register is held
	assign go_s1    = !(item_s1.last_byte && out_valid_q && out_stall);
	assign fire_s1  = valid_s1 && go_s1;
	assign in_stall = valid_s1 && !go_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// window after this byte is shifted in, newest byte at the top
	always_comb begin
		for (int k = 0; k < PATTERN_MAX - 1; k++) begin
			win_nxt[k] = window_q[k+1];
		end
		win_nxt[PATTERN_MAX-1] = item_s1.data_byte;
	end

	// fill count: region start or unreadable byte empties the window
	always_comb begin
		fill_base = (item_s1.new_region || !item_s1.readable) ? '0 : fill_q;
		fill_nxt  = fill_base;
		if (item_s1.readable && (fill_base < FILL_W'(PATTERN_MAX))) begin
			fill_nxt = fill_base + FILL_W'(1);
		end
	end

	mbps_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.win  (win_nxt),
		.fill (fill_nxt),
		.cfg  (cfg),
		.hit  (hit)
	);

	// first byte of a match ending at the current byte
	assign cand_addr = cfg.base_address + pos_q -
	                   mbps_pkg::ADDR_W'(cfg.pattern_length) + 64'd1;

	// latch only the first match of the scan
	assign take      = item_s1.readable && hit && !seen_q;
	assign seen_nxt  = seen_q || take;
	assign first_nxt = take ? cand_addr : first_q;

	// scan state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (fire_s1) begin
			if (item_s1.last_byte) begin
				fill_q  <= '0;
				pos_q   <= '0;
				seen_q  <= 1'b0;
				first_q <= '0;
			end else begin
				fill_q  <= fill_nxt;
				pos_q   <= pos_q + 64'd1;
				seen_q  <= seen_nxt;
				first_q <= first_nxt;
			end
		end
	end

	// window contents only count below the fill mark, so no reset
	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.readable) begin
			window_q <= win_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last_byte) begin
			out_q.found         <= seen_nxt;
			out_q.match_address <= seen_nxt ? first_nxt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/masked_byte_pattern_scan.sv @@
// top level of the masked byte pattern scanner
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_item_t  (one memory byte and flags)
//  out      output     out_valid / out_stall out_item_t (found, match address)
//  cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// One byte per cycle sustained unless a last byte meets a held result;
// bytes pass the input register, and last bytes then load the result register.
// The window compare and the address add sit between those two registers.
// Reset empties the pipeline, clears the scan state and zeroes the configuration registers.
// A stalled result holds the result register; bytes that carry no result
// keep flowing, and a last byte waits in the input register until it is free.
module masked_byte_pattern_scan #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [mbps_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mbps_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mbps_pkg::out_item_t        out_data
);

	mbps_pkg::cfg_t cfg;

	mbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbps_scan #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// testbench for the masked byte pattern scanner: match predictor, drivers and result checks
module tb;
	import mbps_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int WINDOW         = PATTERN_MAX_DEF;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_WAIT       = 16;
	localparam int PRINT_LIMIT    = 200;
	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	// scan predictor and store of expected scan verdicts
	class scan_scoreboard;
		logic [ADDR_W-1:0] base_address;
		logic [63:0]       pattern_low;
		logic [63:0]       pattern_high;
		logic [CARE_W-1:0] care_mask;
		logic [LEN_W-1:0]  pattern_length;
		logic [7:0]        window [WINDOW];
		int                fill;
		logic [ADDR_W-1:0] offset;
		bit                seen;
		logic [ADDR_W-1:0] first_addr;
		out_item_t         verdicts_due [$];
		int                mismatches;

		function new();
			base_address   = '0;
			pattern_low    = '0;
			pattern_high   = '0;
			care_mask      = '0;
			pattern_length = '0;
			mismatches     = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (window[k])
				window[k] = '0;
			fill       = 0;
			offset     = '0;
			seen       = 1'b0;
			first_addr = '0;
		endfunction

		// register write, unused indexes fall through
		function void write_reg(logic [IDX_W-1:0] index, logic [63:0] value);
			case (index)
				REG_BASE_ADDRESS:   base_address = value;
				REG_PATTERN_LOW:    pattern_low = value;
				REG_PATTERN_HIGH:   pattern_high = value;
				REG_CARE_MASK:      care_mask = value[CARE_W-1:0];
				REG_PATTERN_LENGTH: pattern_length = value[LEN_W-1:0];
				default: begin
				end
			endcase
		endfunction

		function logic [7:0] pattern_byte(int i);
			if (i < 8)
				return pattern_low[8*i +: 8];
			return pattern_high[8*(i-8) +: 8];
		endfunction

		// newest len bytes of the window against the masked pattern
		function bit window_hit(int len);
			for (int i = 0; i < len; i++)
				if (care_mask[i] && window[WINDOW-len+i] != pattern_byte(i))
					return 1'b0;
			return 1'b1;
		endfunction

		// advance the scan by one accepted item
		function void note_byte(in_item_t it);
			int        len;
			out_item_t verdict;
			len = pattern_length;
			if (it.new_region || !it.readable)
				fill = 0;
			if (it.readable) begin
				for (int k = 0; k < WINDOW - 1; k++)
					window[k] = window[k+1];
				window[WINDOW-1] = it.data_byte;
				if (fill < WINDOW)
					fill++;
				if (!seen && len >= 1 && len <= WINDOW && fill >= len && window_hit(len)) begin
					seen       = 1'b1;
					first_addr = base_address + offset - ADDR_W'(len - 1);
				end
			end
			offset++;
			if (it.last_byte) begin
				verdict.found         = seen;
				verdict.match_address = seen ? first_addr : '0;
				verdicts_due.push_back(verdict);
				clear_scan();
			end
		endfunction

		task report(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		// compare one accepted result with the oldest verdict
		task check_verdict(out_item_t got);
			out_item_t want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("result with none due: found=%0b address=%h",
					got.found, got.match_address));
				return;
			end
			want = verdicts_due.pop_front();
			if (got.found !== want.found)
				report($sformatf("found %0b, expected %0b", got.found, want.found));
			if (got.match_address !== want.match_address)
				report($sformatf("match_address %h, expected %h",
					got.match_address, want.match_address));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [IDX_W-1:0]    cfg_index;
	logic [63:0]         cfg_data;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;

	scan_scoreboard sb = new();
	bit             send_idle;
	bit             recv_idle;
	int             quiet_cycles = 0;

	masked_byte_pattern_scan uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_wait(bit on);
		if (!on || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic in_item_t mk(logic [7:0] d, logic r, logic nr, logic l);
		return {d, r, nr, l};
	endfunction

	// offer one item and hold it until taken
	task automatic put_byte(in_item_t it);
		int gap;
		gap = draw_wait(send_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic set_reg(logic [IDX_W-1:0] index, logic [63:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_reg(index, value);
	endtask

	// drain all verdicts, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_random_setup(int phase_no);
		logic [63:0]       addr;
		logic [63:0]       noise;
		logic [CARE_W-1:0] care;
		logic [LEN_W-1:0]  len;
		noise = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: addr = '0;
			1: addr = '1;
			2: addr = '1 - 64'($urandom_range(0, 40));
			default: addr = {$urandom, $urandom};
		endcase
		case ($urandom_range(0, 3))
			0: care = '0;
			1: care = '1;
			2: care = CARE_W'($urandom) & CARE_W'($urandom);
			default: care = CARE_W'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: len = '0;
			1: len = LEN_W'($urandom_range(WINDOW + 1, (1 << LEN_W) - 1));
			2: len = LEN_W'(1);
			3: len = LEN_W'(WINDOW);
			default: len = LEN_W'($urandom_range(1, WINDOW));
		endcase
		// the first two phases pin the extremes
		if (phase_no == 0) begin
			addr = '1;
			care = '1;
			len  = LEN_W'(WINDOW);
		end else if (phase_no == 1) begin
			addr = '0;
			care = '0;
			len  = LEN_W'(1);
		end
		set_reg(REG_PATTERN_LENGTH, {noise[63:LEN_W], len});
		set_reg(REG_CARE_MASK, {noise[63:CARE_W], care});
		set_reg(REG_BASE_ADDRESS, addr);
		set_reg(REG_PATTERN_LOW, {$urandom, $urandom});
		set_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
		if ($urandom_range(0, 1))
			set_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
	endtask

	// one scan: planted pattern copies, some broken, among noise bytes
	task automatic random_scan(output int count);
		in_item_t scan_q [$];
		in_item_t it;
		int       n;
		int       len;
		int       breakpt;
		n   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
		len = sb.pattern_length;
		while (scan_q.size() < n) begin
			if (len >= 1 && len <= WINDOW && $urandom_range(0, 3) == 0) begin
				breakpt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
				for (int i = 0; i < len; i++) begin
					it.data_byte  = sb.care_mask[i] ? sb.pattern_byte(i) : 8'($urandom);
					it.readable   = 1'b1;
					it.new_region = (i == 0) && ($urandom_range(0, 3) == 0);
					it.last_byte  = 1'b0;
					if (i == breakpt) begin
						case ($urandom_range(0, 2))
							0: it.data_byte ^= 8'(1 << $urandom_range(0, 7));
							1: it.readable = 1'b0;
							default: it.new_region = 1'b1;
						endcase
					end
					scan_q.push_back(it);
				end
			end else begin
				it.data_byte = ($urandom_range(0, 2) == 0) ?
					sb.pattern_byte($urandom_range(0, WINDOW - 1)) : 8'($urandom);
				it.readable   = ($urandom_range(0, 9) != 0);
				it.new_region = ($urandom_range(0, 11) == 0);
				it.last_byte  = 1'b0;
				scan_q.push_back(it);
			end
		end
		scan_q[scan_q.size()-1].last_byte = 1'b1;
		foreach (scan_q[k])
			put_byte(scan_q[k]);
		count = scan_q.size();
	endtask

	// item and result monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_byte(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(out_data);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side stall
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			hold = draw_wait(recv_idle);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// main sequence
	initial begin
		int sent;
		int done;
		int n;
		int phase_items;
		int phase_no;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_BASE_ADDRESS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		send_idle = 1'b0;
		recv_idle = 1'b1;
		sent      = 0;
		phase_no  = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pattern 00 ff ?? a5 with byte 2 a wildcard, base just below the wrap
		set_reg(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
		set_reg(REG_PATTERN_LOW, 64'h1122_3344_A55A_FF00);
		set_reg(REG_PATTERN_HIGH, 64'hFFEE_DDCC_BBAA_9988);
		set_reg(REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_000B);
		set_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE4);
		cfg_wr_en <= 1'b0;

		// match whose address wraps to zero, then a later match that is ignored
		put_byte(mk(8'h11, 1, 0, 0));
		put_byte(mk(8'h22, 1, 0, 0));
		put_byte(mk(8'h00, 1, 0, 0));
		put_byte(mk(8'hFF, 1, 0, 0));
		put_byte(mk(8'h33, 1, 0, 0));
		put_byte(mk(8'hA5, 1, 0, 0));
		put_byte(mk(8'h00, 1, 0, 0));
		put_byte(mk(8'hFF, 1, 0, 0));
		put_byte(mk(8'h5A, 1, 0, 0));
		put_byte(mk(8'hA5, 1, 0, 1));
		// region start splits the pattern, scan ends on an unreadable byte
		put_byte(mk(8'h00, 1, 0, 0));
		put_byte(mk(8'hFF, 1, 0, 0));
		put_byte(mk(8'h5A, 1, 1, 0));
		put_byte(mk(8'hA5, 1, 0, 0));
		put_byte(mk(8'h00, 0, 0, 1));
		// unreadable region start, then a match opening a new region
		put_byte(mk(8'h00, 1, 0, 0));
		put_byte(mk(8'hFF, 0, 1, 0));
		put_byte(mk(8'h00, 1, 1, 0));
		put_byte(mk(8'hFF, 1, 0, 0));
		put_byte(mk(8'hC3, 1, 0, 0));
		put_byte(mk(8'hA5, 1, 0, 1));
		settle();

		// zero length with every position a wildcard
		set_reg(REG_CARE_MASK, '0);
		set_reg(REG_PATTERN_LENGTH, '0);
		cfg_wr_en <= 1'b0;
		put_byte(mk(8'h00, 1, 0, 0));
		put_byte(mk(8'hFF, 1, 1, 1));
		settle();

		// length beyond the window
		set_reg(REG_PATTERN_LENGTH, 64'((1 << LEN_W) - 1));
		cfg_wr_en <= 1'b0;
		put_byte(mk(8'hA5, 1, 0, 0));
		put_byte(mk(8'h5A, 0, 1, 1));
		settle();

		// random phases, each with its own setup and idling
		while (sent < RANDOM_ITEMS) begin
			load_random_setup(phase_no);
			send_idle   = ($urandom_range(0, 2) != 0);
			recv_idle   = ($urandom_range(0, 2) != 0);
			phase_items = $urandom_range(60, 200);
			done        = 0;
			while (done < phase_items) begin
				random_scan(n);
				done += n;
			end
			sent += done;
			phase_no++;
			settle();
		end

		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg.sv
hw/rtl/mbps_match.sv
hw/rtl/mbps_scan.sv
hw/rtl/masked_byte_pattern_scan.sv
bench/tb.sv
